FILE: rtl/ohacc_pkg.sv
// Orbit histogram accumulator: shared types, constants and codes.
// Used by every module of the block but ohacc_ram; depends on nothing.
`timescale 1ns / 1ps

package ohacc_pkg;

	// default sizes, handed down as module parameters
	localparam int DEF_BIN_COUNT   = 65536;
	localparam int DEF_ORBIT_DEPTH = 1024;
	localparam int DEF_COORD_BITS  = 32;

	// orbit length field wide enough for the largest orbit buffer
	localparam int LEN_W = 17;
	// bin index arithmetic, wide enough for the largest bin count
	localparam int IDX_W = 21;
	// fraction bits dropped after coordinate times scale (28 + 16)
	localparam int FRAC_SHIFT = 44;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_H  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_H = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_V = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_W   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_H   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP    = 3'd6;

	// input word kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// queued job kinds
	localparam logic JOB_CLOSE = 1'b0;
	localparam logic JOB_READ  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] point_real;
		logic signed [31:0] point_imag;
		logic signed [31:0] origin_real;
		logic signed [31:0] origin_imag;
		logic [9:0]         step_index;
		logic               end_of_batch;
		logic [15:0]        bin_index;
	} in_t;

	// one bin of the histogram and one result word share this layout
	typedef struct packed {
		logic [31:0]        hit_count;
		logic [31:0]        start_hit_count;
		logic [31:0]        start_step_sum;
		logic [31:0]        length_sum;
		logic [31:0]        reached_step_sum;
		logic signed [63:0] origin_real_sum;
		logic signed [63:0] origin_imag_sum;
		logic signed [63:0] previous_real_sum;
		logic signed [63:0] previous_imag_sum;
	} out_t;

	typedef struct packed {
		logic               kind;
		logic [15:0]        bin_index;
		logic [LEN_W-1:0]   len;
		logic signed [31:0] origin_re;
		logic signed [31:0] origin_im;
	} job_t;

	typedef struct packed {
		logic [30:0] half_w;
		logic [30:0] half_h;
		logic [31:0] scale_h;
		logic [31:0] scale_v;
		logic [8:0]  img_w;
		logic [8:0]  img_h;
		logic [10:0] skip;
	} cfg_t;

endpackage

FILE: rtl/ohacc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ohacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/ohacc_map.sv
// Point to bin mapping pipeline: offset, magnitude, scale multiply, pixel check.
// Depends on ohacc_pkg. in_valid is registered through v_s1, v_s2 and v_s3 to out_valid.
`timescale 1ns / 1ps

module ohacc_map import ohacc_pkg::*; #(
	parameter int BIN_COUNT = DEF_BIN_COUNT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         in_valid,
	input  logic signed [31:0]           re,
	input  logic signed [31:0]           im,
	output logic                         out_valid,
	output logic                         out_ok,
	output logic [$clog2(BIN_COUNT)-1:0] out_idx
);

	localparam int BW = $clog2(BIN_COUNT);

	logic [32:0] sum_re, sum_im, neg_re, neg_im;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] mag_re_s1, mag_im_s1;
	logic        sgn_re_s1, sgn_im_s1, sgn_re_s2, sgn_im_s2;
	logic [63:0] prod_re_s2, prod_im_s2;
	logic [19:0] q_re, q_im;
	logic        ok_re, ok_im;
	logic [8:0]  col, row;
	logic [17:0] row_off;
	logic [IDX_W-1:0] idx_c, idx_s3;
	logic        ok_s3;

	// offset by half the plane, take sign and magnitude
	assign sum_re = {re[31], re} + {2'b00, cfg.half_w};
	assign sum_im = {im[31], im} + {2'b00, cfg.half_h};
	assign neg_re = 33'd0 - sum_re;
	assign neg_im = 33'd0 - sum_im;

	// pixel coordinate, truncated toward zero
	assign q_re  = prod_re_s2[63:FRAC_SHIFT];
	assign q_im  = prod_im_s2[63:FRAC_SHIFT];
	assign ok_re = sgn_re_s2 ? (q_re == 20'd0 && cfg.img_w != 9'd0) : (q_re < 20'(cfg.img_w));
	assign ok_im = sgn_im_s2 ? (q_im == 20'd0 && cfg.img_h != 9'd0) : (q_im < 20'(cfg.img_h));
	assign col   = sgn_re_s2 ? 9'd0 : q_re[8:0];
	assign row   = sgn_im_s2 ? 9'd0 : q_im[8:0];
	assign row_off = row * cfg.img_w;
	assign idx_c = IDX_W'(col) + IDX_W'(row_off);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pipeline data
	always_ff @(posedge clk) begin
		sgn_re_s1  <= sum_re[32];
		sgn_im_s1  <= sum_im[32];
		mag_re_s1  <= sum_re[32] ? neg_re[31:0] : sum_re[31:0];
		mag_im_s1  <= sum_im[32] ? neg_im[31:0] : sum_im[31:0];
		sgn_re_s2  <= sgn_re_s1;
		sgn_im_s2  <= sgn_im_s1;
		prod_re_s2 <= 64'(mag_re_s1) * 64'(cfg.scale_h);
		prod_im_s2 <= 64'(mag_im_s1) * 64'(cfg.scale_v);
		ok_s3      <= ok_re && ok_im;
		idx_s3     <= idx_c;
	end

	assign out_valid = v_s3;
	assign out_ok    = ok_s3 && (idx_s3 < IDX_W'(BIN_COUNT));
	assign out_idx   = idx_s3[BW-1:0];

endmodule

FILE: rtl/ohacc_queue.sv
// Two-word job queue between the front and the back.
// Depends on ohacc_pkg.
`timescale 1ns / 1ps

module ohacc_queue import ohacc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

endmodule

FILE: rtl/ohacc_front.sv
// Front end: takes input words, buffers orbit points, queues close and read jobs.
// Depends on ohacc_pkg.
`timescale 1ns / 1ps

module ohacc_front import ohacc_pkg::*; #(
	parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  in_t                            in_word,
	input  logic                           clearing,
	input  logic                           orbit_done,
	input  logic                           q_full,
	output logic                           push,
	output job_t                           push_job,
	output logic                           buf_we,
	output logic [$clog2(ORBIT_DEPTH)-1:0] buf_waddr,
	output logic [2*((COORD_BITS < 32) ? COORD_BITS : 32)-1:0] buf_wdata
);

	localparam int CB  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int LW  = $clog2(ORBIT_DEPTH + 1);
	localparam int OAW = $clog2(ORBIT_DEPTH);

	logic [LW-1:0]      len_q, new_len;
	logic               busy_q;
	logic signed [31:0] org_re_q, org_im_q, org_re_c, org_im_c, in_org_re, in_org_im;
	logic               is_read, brk, can, read_go, brk_go, smp_go, close_now;

	// origin reduced to the coordinate width, sign extended
	assign in_org_re = 32'(signed'(in_word.origin_real[CB-1:0]));
	assign in_org_im = 32'(signed'(in_word.origin_imag[CB-1:0]));
	assign org_re_c  = (len_q == '0) ? in_org_re : org_re_q;
	assign org_im_c  = (len_q == '0) ? in_org_im : org_im_q;

	// classify the word at the port
	assign is_read = (in_word.kind == KIND_READ);
	assign brk     = (len_q != '0) && (LEN_W'(in_word.step_index) != LEN_W'(len_q));
	assign can     = !clearing && !q_full;
	assign read_go = in_valid && is_read && can;
	assign brk_go  = in_valid && !is_read && !busy_q && brk && can;
	assign smp_go  = in_valid && !is_read && !busy_q && !brk && can;
	assign in_stall = !(read_go || smp_go);

	assign new_len   = len_q + LW'(1);
	assign close_now = smp_go && (new_len == LW'(ORBIT_DEPTH) || in_word.end_of_batch);

	// job to the back
	assign push = read_go || brk_go || close_now;
	always_comb begin
		push_job.kind      = is_read ? JOB_READ : JOB_CLOSE;
		push_job.bin_index = in_word.bin_index;
		push_job.len       = brk_go ? LEN_W'(len_q) : LEN_W'(new_len);
		push_job.origin_re = brk_go ? org_re_q : org_re_c;
		push_job.origin_im = brk_go ? org_im_q : org_im_c;
	end

	// orbit buffer write
	assign buf_we    = smp_go;
	assign buf_waddr = len_q[OAW-1:0];
	assign buf_wdata = {in_word.point_imag[CB-1:0], in_word.point_real[CB-1:0]};

	// orbit length and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (brk_go || close_now) begin
				len_q <= '0;
			end else if (smp_go) begin
				len_q <= new_len;
			end
			if (brk_go || close_now) begin
				busy_q <= 1'b1;
			end else if (orbit_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// origin of the orbit being buffered
	always_ff @(posedge clk) begin
		if (smp_go && len_q == '0) begin
			org_re_q <= in_org_re;
			org_im_q <= in_org_im;
		end
	end

endmodule

FILE: rtl/ohacc_back.sv
// Back end: clears the bins after reset, bins closed orbits, serves bin reads (a read clears the bin).
// Depends on ohacc_pkg, ohacc_map and ohacc_ram.
`timescale 1ns / 1ps

module ohacc_back import ohacc_pkg::*; #(
	parameter int BIN_COUNT   = DEF_BIN_COUNT,
	parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           q_empty,
	input  job_t                           q_head,
	output logic                           q_pop,
	output logic                           orbit_done,
	output logic                           clearing,
	output logic [$clog2(ORBIT_DEPTH)-1:0] buf_raddr,
	input  logic [2*((COORD_BITS < 32) ? COORD_BITS : 32)-1:0] buf_rdata,
	output logic                           out_valid,
	input  logic                           out_stall,
	output out_t                           out_word
);

	localparam int CB  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int OAW = $clog2(ORBIT_DEPTH);
	localparam int BW  = $clog2(BIN_COUNT);

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RD0    = 4'd2;
	localparam logic [3:0] ST_RD1    = 4'd3;
	localparam logic [3:0] ST_OMAP   = 4'd4;
	localparam logic [3:0] ST_OWAIT  = 4'd5;
	localparam logic [3:0] ST_OUPD   = 4'd6;
	localparam logic [3:0] ST_PSTART = 4'd7;
	localparam logic [3:0] ST_PPREV  = 4'd8;
	localparam logic [3:0] ST_PRD    = 4'd9;
	localparam logic [3:0] ST_PMAP   = 4'd10;
	localparam logic [3:0] ST_PWAIT  = 4'd11;
	localparam logic [3:0] ST_PUPD   = 4'd12;
	localparam logic [3:0] ST_PNEXT  = 4'd13;
	localparam logic [3:0] ST_DONE   = 4'd14;

	logic [3:0]         st_q;
	job_t               job_q;
	logic [LEN_W-1:0]   j_q, j_inc, skip_ext, skip_m1;
	logic signed [31:0] prev_re_q, prev_im_q, cur_re_q, cur_im_q;
	logic signed [31:0] buf_re, buf_im, map_re, map_im;
	logic [BW-1:0]      clr_q, idx_q, bi_addr, map_idx, bin_raddr, bin_waddr;
	logic [IDX_W-1:0]   bi_ext;
	logic               bi_ok, map_in_valid, map_out_valid, map_ok, bin_we;
	out_t               bin_rdata, bin_wdata, upd_start, upd_pt, out_q;
	logic               out_valid_q;

	assign clearing   = (st_q == ST_CLR);
	assign orbit_done = (st_q == ST_DONE);
	assign q_pop      = (st_q == ST_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;
	assign out_word   = out_q;

	// buffered point, sign extended
	assign buf_re = 32'(signed'(buf_rdata[CB-1:0]));
	assign buf_im = 32'(signed'(buf_rdata[2*CB-1:CB]));

	assign skip_ext = LEN_W'(cfg.skip);
	assign skip_m1  = skip_ext - LEN_W'(1);
	assign j_inc    = j_q + LEN_W'(1);
	assign buf_raddr = (st_q == ST_PSTART) ? skip_m1[OAW-1:0] : j_q[OAW-1:0];

	// read request address check
	assign bi_ext  = IDX_W'(job_q.bin_index);
	assign bi_ok   = bi_ext < IDX_W'(BIN_COUNT);
	assign bi_addr = bi_ext[BW-1:0];

	// mapping unit feeds
	assign map_in_valid = (st_q == ST_OMAP) || (st_q == ST_PMAP);
	assign map_re = (st_q == ST_OMAP) ? job_q.origin_re : buf_re;
	assign map_im = (st_q == ST_OMAP) ? job_q.origin_im : buf_im;

	ohacc_map #(
		.BIN_COUNT(BIN_COUNT)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (map_in_valid),
		.re       (map_re),
		.im       (map_im),
		.out_valid(map_out_valid),
		.out_ok   (map_ok),
		.out_idx  (map_idx)
	);

	// bin updates
	always_comb begin
		upd_start = bin_rdata;
		upd_start.start_hit_count = bin_rdata.start_hit_count + 32'd1;
		upd_start.start_step_sum  = bin_rdata.start_step_sum + 32'(job_q.len);
		upd_pt = bin_rdata;
		upd_pt.hit_count         = bin_rdata.hit_count + 32'd1;
		upd_pt.length_sum        = bin_rdata.length_sum + 32'(job_q.len);
		upd_pt.reached_step_sum  = bin_rdata.reached_step_sum + 32'(j_q);
		upd_pt.origin_real_sum   = bin_rdata.origin_real_sum + 64'(job_q.origin_re);
		upd_pt.origin_imag_sum   = bin_rdata.origin_imag_sum + 64'(job_q.origin_im);
		upd_pt.previous_real_sum = bin_rdata.previous_real_sum + 64'(prev_re_q);
		upd_pt.previous_imag_sum = bin_rdata.previous_imag_sum + 64'(prev_im_q);
	end

	// bin memory port select
	always_comb begin
		bin_raddr = (st_q == ST_RD0) ? bi_addr : map_idx;
		bin_we    = 1'b0;
		bin_waddr = idx_q;
		bin_wdata = '0;
		case (st_q)
			ST_CLR: begin
				bin_we    = 1'b1;
				bin_waddr = clr_q;
			end
			ST_RD1: begin
				bin_we    = bi_ok;
				bin_waddr = bi_addr;
			end
			ST_OUPD: begin
				bin_we    = 1'b1;
				bin_wdata = upd_start;
			end
			ST_PUPD: begin
				bin_we    = 1'b1;
				bin_wdata = upd_pt;
			end
			default: begin
				bin_we = 1'b0;
			end
		endcase
	end

	ohacc_ram #(
		.WIDTH($bits(out_t)),
		.DEPTH(BIN_COUNT)
	) u_bins (
		.clk  (clk),
		.we   (bin_we),
		.waddr(bin_waddr),
		.wdata(bin_wdata),
		.raddr(bin_raddr),
		.rdata(bin_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BIN_COUNT - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						st_q <= (q_head.kind == JOB_READ) ? ST_RD0 : ST_OMAP;
					end
				end
				ST_RD0: begin
					if (!out_valid_q) begin
						st_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					out_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_OMAP: st_q <= ST_OWAIT;
				ST_OWAIT: begin
					if (map_out_valid) begin
						st_q <= map_ok ? ST_OUPD : ST_PSTART;
					end
				end
				ST_OUPD: st_q <= ST_PSTART;
				ST_PSTART: begin
					if (skip_ext >= job_q.len) begin
						st_q <= ST_DONE;
					end else if (skip_ext != '0) begin
						st_q <= ST_PPREV;
					end else begin
						st_q <= ST_PRD;
					end
				end
				ST_PPREV: st_q <= ST_PRD;
				ST_PRD:   st_q <= ST_PMAP;
				ST_PMAP:  st_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (map_out_valid) begin
						st_q <= map_ok ? ST_PUPD : ST_PNEXT;
					end
				end
				ST_PUPD: st_q <= ST_PNEXT;
				ST_PNEXT: begin
					st_q <= (j_inc >= job_q.len) ? ST_DONE : ST_PRD;
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// job data, walk position, points, result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if ((st_q == ST_OWAIT || st_q == ST_PWAIT) && map_out_valid) begin
			idx_q <= map_idx;
		end
		if (st_q == ST_PSTART) begin
			j_q       <= skip_ext;
			prev_re_q <= '0;
			prev_im_q <= '0;
		end
		if (st_q == ST_PPREV) begin
			prev_re_q <= buf_re;
			prev_im_q <= buf_im;
		end
		if (st_q == ST_PMAP) begin
			cur_re_q <= buf_re;
			cur_im_q <= buf_im;
		end
		if (st_q == ST_PNEXT) begin
			prev_re_q <= cur_re_q;
			prev_im_q <= cur_im_q;
			j_q       <= j_inc;
		end
		if (st_q == ST_RD1) begin
			out_q <= bi_ok ? bin_rdata : '0;
		end
	end

endmodule

FILE: rtl/orbit_histogram_accumulator.sv
// Orbit histogram accumulator top level: configuration registers and wiring.
// Depends on ohacc_pkg, ohacc_front, ohacc_queue, ohacc_ram and ohacc_back.
`timescale 1ns / 1ps

// After reset the block zeroes its bin memory, one bin per cycle, and takes
// no input word during that pass (configuration writes are taken). A sample
// that continues the current orbit is taken unless the job queue is full or
// a close job is still in progress. When an orbit closes (step index break,
// full buffer or end of batch) a close job goes to the back end, and further
// samples wait until it is done: the back end maps the orbit origin, then
// walks the orbit buffer serially, with a read-modify-write of the bin memory
// for the origin and for each point when it lands in a bin. A bin read returns
// one result word and clears the bin; reads queue behind close jobs and see
// their effect. The user must write configuration only while the block is
// idle; the block itself does not enforce this.

module orbit_histogram_accumulator import ohacc_pkg::*; #(
	parameter int BIN_COUNT   = DEF_BIN_COUNT,
	parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_word
);

	localparam int CB  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int OAW = $clog2(ORBIT_DEPTH);

	cfg_t          cfg_q;
	logic          clearing, orbit_done, q_full, q_empty, push, pop;
	job_t          push_job, q_head;
	logic          buf_we;
	logic [OAW-1:0] buf_waddr, buf_raddr;
	logic [2*CB-1:0] buf_wdata, buf_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_w  <= 31'd536870912;
			cfg_q.half_h  <= 31'd536870912;
			cfg_q.scale_h <= 32'd4194304;
			cfg_q.scale_v <= 32'd4194304;
			cfg_q.img_w   <= 9'd256;
			cfg_q.img_h   <= 9'd256;
			cfg_q.skip    <= 11'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_W:  cfg_q.half_w  <= cfg_data[30:0];
				REG_HALF_H:  cfg_q.half_h  <= cfg_data[30:0];
				REG_SCALE_H: cfg_q.scale_h <= cfg_data;
				REG_SCALE_V: cfg_q.scale_v <= cfg_data;
				REG_IMG_W:   cfg_q.img_w   <= cfg_data[8:0];
				REG_IMG_H:   cfg_q.img_h   <= cfg_data[8:0];
				REG_SKIP:    cfg_q.skip    <= cfg_data[10:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	ohacc_front #(
		.ORBIT_DEPTH(ORBIT_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.clearing  (clearing),
		.orbit_done(orbit_done),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata)
	);

	ohacc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	// orbit point buffer
	ohacc_ram #(
		.WIDTH(2 * CB),
		.DEPTH(ORBIT_DEPTH)
	) u_orbit (
		.clk  (clk),
		.we   (buf_we),
		.waddr(buf_waddr),
		.wdata(buf_wdata),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	ohacc_back #(
		.BIN_COUNT  (BIN_COUNT),
		.ORBIT_DEPTH(ORBIT_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (pop),
		.orbit_done(orbit_done),
		.clearing  (clearing),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
